/* hw/rtl/jss_pkg.sv */
// Shared types and constants for the JTAG scan sequencer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package jss_pkg;

    localparam int DEFAULT_PORTS = 4;
    localparam int RESET_CLOCKS  = 5;
    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic emit;   // write one TCK cycle into the output register
        logic tms;
        logic shift;  // this cycle shifts a data bit
        logic done;   // byte_done for this cycle
        logic last;   // final cycle of the transaction
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       port_ok;
        logic       ir;
        logic       first;
        logic       lastb;
        logic [3:0] bc;
        logic       empty;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/jss_datapath.sv */
// Datapath of the JTAG scan sequencer: item registers, read merge, TDI shifter
// and the output register. Depends on jss_pkg.
`default_nettype none

module jss_datapath
    import jss_pkg::*;
#(
    parameter int PORTS = DEFAULT_PORTS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire logic [1:0] i_command,
    input  wire logic [1:0] i_port_index,
    input  wire logic       i_select_ir,
    input  wire logic       i_read_mode,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic [3:0] i_bit_count,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_tdo_bits,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_port_index_out,
    output logic            o_tms_level,
    output logic            o_tdi_level,
    output logic [7:0]      o_result_byte,
    output logic            o_byte_done,
    output logic            o_last
);

    localparam logic [4:0] PortsW = 5'(PORTS);

    logic [1:0] r_cmd;
    logic [1:0] r_port;
    logic       r_port_ok;
    logic       r_ir;
    logic       r_rd;
    logic       r_first;
    logic       r_lastb;
    logic [3:0] r_bc;
    logic [7:0] r_sh;
    logic [7:0] r_rb;

    logic [3:0] bc_clamp;
    logic [7:0] mask;
    logic [7:0] rb;

    always_comb begin
        if (!i_last_byte || i_bit_count > BYTE_BITS) begin
            bc_clamp = BYTE_BITS;
        end else begin
            bc_clamp = i_bit_count;
        end
        mask = 8'(BYTE_FULL << (BYTE_BITS - bc_clamp));
        rb   = i_read_mode ? ((i_data_byte & ~mask) | (i_tdo_bits & mask)) : i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_command;
            r_port    <= i_port_index;
            r_port_ok <= ({3'b000, i_port_index} < PortsW);
            r_ir      <= i_select_ir;
            r_rd      <= i_read_mode;
            r_first   <= i_first_byte;
            r_lastb   <= i_last_byte;
            r_bc      <= bc_clamp;
            r_sh      <= i_data_byte;
            r_rb      <= rb;
        end else if (i_cmd.emit && i_cmd.shift) begin
            r_sh <= {r_sh[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_port_index_out <= r_port;
            o_tms_level      <= i_cmd.tms;
            o_tdi_level      <= i_cmd.shift && !r_rd && r_sh[7];
            o_result_byte    <= i_cmd.done ? r_rb : 8'h00;
            o_byte_done      <= i_cmd.done;
            o_last           <= i_cmd.last;
        end
    end

    always_comb begin
        o_status.cmd      = r_cmd;
        o_status.port_ok  = r_port_ok;
        o_status.ir       = r_ir;
        o_status.first    = r_first;
        o_status.lastb    = r_lastb;
        o_status.bc       = r_bc;
        o_status.empty    = r_first && r_lastb && (r_bc == 4'd0);
        o_status.out_free = !o_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

/* hw/rtl/jss_controller.sv */
// Controller of the JTAG scan sequencer: walks the TAP clock sequence of one
// transaction, one TCK cycle per free output slot. Depends on jss_pkg.
`default_nettype none

module jss_controller
    import jss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_RST1     = 4'd2;
    localparam logic [3:0] S_RST0     = 4'd3;
    localparam logic [3:0] S_RUN      = 4'd4;
    localparam logic [3:0] S_SEL_DR   = 4'd5;
    localparam logic [3:0] S_SEL_IR   = 4'd6;
    localparam logic [3:0] S_CAPTURE  = 4'd7;
    localparam logic [3:0] S_TO_SHIFT = 4'd8;
    localparam logic [3:0] S_ZERO     = 4'd9;
    localparam logic [3:0] S_SHIFT    = 4'd10;
    localparam logic [3:0] S_UPDATE   = 4'd11;

    localparam logic [2:0] RstLast = 3'(RESET_CLOCKS - 1);

    logic [3:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       fin;

    assign fin        = ({1'b0, r_cnt} + 4'd1) == i_status.bc;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = 3'd0;
                if (!i_status.port_ok) begin
                    n_state = S_IDLE;
                end else begin
                    unique case (i_status.cmd)
                        CMD_RESET: n_state = S_RST1;
                        CMD_RUN:   n_state = S_RUN;
                        CMD_SCAN: begin
                            if (i_status.first) begin
                                n_state = S_SEL_DR;
                            end else if (i_status.bc == 4'd0) begin
                                n_state = S_ZERO;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RST1: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.tms  = 1'b1;
                    if (r_cnt == RstLast) begin
                        n_state = S_RST0;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_RST0, S_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SEL_DR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.tms  = 1'b1;
                    n_state    = i_status.ir ? S_SEL_IR : S_CAPTURE;
                end
            end
            S_SEL_IR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.tms  = 1'b1;
                    n_state    = S_CAPTURE;
                end
            end
            S_CAPTURE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    // The empty scan skips the move to Shift-DR/IR.
                    n_state    = i_status.empty ? S_ZERO : S_TO_SHIFT;
                end
            end
            S_TO_SHIFT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = (i_status.bc == 4'd0) ? S_ZERO : S_SHIFT;
                end
            end
            S_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.tms  = 1'b1;
                    o_cmd.done = 1'b1;
                    o_cmd.last = !i_status.lastb;
                    n_state    = i_status.lastb ? S_UPDATE : S_IDLE;
                end
            end
            S_SHIFT: begin
                if (i_status.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.shift = 1'b1;
                    o_cmd.tms   = i_status.lastb && fin;
                    o_cmd.done  = fin;
                    o_cmd.last  = fin && !i_status.lastb;
                    if (fin) begin
                        n_state = i_status.lastb ? S_UPDATE : S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.tms  = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/jtag_scan_sequencer_top.sv */
// JTAG scan sequencer: one transaction in, one TCK cycle per result out.
// After acceptance the item is loaded, the controller dispatches it, and the first
// result enters the output register from the first TCK state that finds a free slot.
// One transaction at a time, with up to 13 TCK results for a scan byte, one per free
// output slot, set by the sequencing FSM; one with no clocks returns from dispatch to idle.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
`default_nettype none

module jtag_scan_sequencer_top
    import jss_pkg::*;
#(
    parameter int PORTS = DEFAULT_PORTS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [1:0] i_port_index,
    input  wire logic       i_select_ir,
    input  wire logic       i_read_mode,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic [3:0] i_bit_count,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_tdo_bits,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_port_index_out,
    output logic            o_tms_level,
    output logic            o_tdi_level,
    output logic [7:0]      o_result_byte,
    output logic            o_byte_done,
    output logic            o_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    jss_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    jss_datapath #(
        .PORTS (PORTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_command        (i_command),
        .i_port_index     (i_port_index),
        .i_select_ir      (i_select_ir),
        .i_read_mode      (i_read_mode),
        .i_first_byte     (i_first_byte),
        .i_last_byte      (i_last_byte),
        .i_bit_count      (i_bit_count),
        .i_data_byte      (i_data_byte),
        .i_tdo_bits       (i_tdo_bits),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_port_index_out (o_port_index_out),
        .o_tms_level      (o_tms_level),
        .o_tdi_level      (o_tdi_level),
        .o_result_byte    (o_result_byte),
        .o_byte_done      (o_byte_done),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for jtag_scan_sequencer_top. It sends reset, run and scan
// transactions, predicts every TCK cycle that each one causes and checks the results in order.
// It depends only on jss_pkg and the sequencer RTL.

module tb_top
    import jss_pkg::*;
();

    localparam int         TB_PORTS     = DEFAULT_PORTS;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] port;
        logic       ir;
        logic       rd;
        logic       first;
        logic       lastb;
        logic [3:0] bc;
        logic [7:0] data;
        logic [7:0] tdo;
    } jtag_item_t;

    typedef struct packed {
        logic [1:0] port;
        logic       tms;
        logic       tdi;
        logic [7:0] rbyte;
        logic       done;
        logic       last;
    } tck_cycle_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [1:0] command      = '0;
    logic [1:0] port_index   = '0;
    logic       select_ir    = 1'b0;
    logic       read_mode    = 1'b0;
    logic       first_byte   = 1'b0;
    logic       last_byte    = 1'b0;
    logic [3:0] bit_count    = '0;
    logic [7:0] data_byte    = '0;
    logic [7:0] tdo_bits     = '0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [1:0] port_out;
    logic       tms_level;
    logic       tdi_level;
    logic [7:0] result_byte;
    logic       byte_done;
    logic       last;

    tck_cycle_t pending_tck[$];
    tck_cycle_t oldest_tck;
    int         error_count   = 0;
    int         cycle_count   = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         hold_cycles   = 0;

    jtag_scan_sequencer_top #(.PORTS(TB_PORTS)) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (command),
        .i_port_index     (port_index),
        .i_select_ir      (select_ir),
        .i_read_mode      (read_mode),
        .i_first_byte     (first_byte),
        .i_last_byte      (last_byte),
        .i_bit_count      (bit_count),
        .i_data_byte      (data_byte),
        .i_tdo_bits       (tdo_bits),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_port_index_out (port_out),
        .o_tms_level      (tms_level),
        .o_tdi_level      (tdi_level),
        .o_result_byte    (result_byte),
        .o_byte_done      (byte_done),
        .o_last           (last)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // A long hold-off takes priority over the random stall pattern.
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic tck_cycle_t tck(input logic [1:0] port, input logic tms,
                                       input logic tdi, input logic [7:0] rbyte,
                                       input logic done);
        tck_cycle_t c;
        c.port  = port;
        c.tms   = tms;
        c.tdi   = tdi;
        c.rbyte = done ? rbyte : 8'h00;
        c.done  = done;
        c.last  = 1'b0;
        return c;
    endfunction

    function automatic void predict_tck_cycles(input jtag_item_t it);
        tck_cycle_t cyc[$];
        logic [3:0] nbits;
        logic [7:0] mask;
        logic [7:0] merged;
        logic       empty;
        logic       fin;
        int         k;
        if (int'(it.port) >= TB_PORTS)
            return;
        case (it.command)
            CMD_RESET: begin
                repeat (RESET_CLOCKS) cyc.push_back(tck(it.port, 1'b1, 1'b0, 8'h00, 1'b0));
                cyc.push_back(tck(it.port, 1'b0, 1'b0, 8'h00, 1'b0));
            end
            CMD_RUN: begin
                cyc.push_back(tck(it.port, 1'b0, 1'b0, 8'h00, 1'b0));
            end
            CMD_SCAN: begin
                if (!it.lastb || it.bc > BYTE_BITS)
                    nbits = BYTE_BITS;
                else
                    nbits = it.bc;
                empty = it.first && it.lastb && nbits == 0;
                // Select-DR, Select-IR for an IR scan, Capture and, unless empty, the move to Shift.
                if (it.first) begin
                    cyc.push_back(tck(it.port, 1'b1, 1'b0, 8'h00, 1'b0));
                    if (it.ir)
                        cyc.push_back(tck(it.port, 1'b1, 1'b0, 8'h00, 1'b0));
                    cyc.push_back(tck(it.port, 1'b0, 1'b0, 8'h00, 1'b0));
                    if (!empty)
                        cyc.push_back(tck(it.port, 1'b0, 1'b0, 8'h00, 1'b0));
                end
                mask   = (nbits == 0) ? 8'h00 : BYTE_FULL << (BYTE_BITS - nbits);
                merged = it.rd ? ((it.data & ~mask) | (it.tdo & mask)) : it.data;
                if (nbits == 0) begin
                    cyc.push_back(tck(it.port, 1'b1, 1'b0, merged, 1'b1));
                end else begin
                    for (k = 0; k < int'(nbits); k++) begin
                        fin = (k == int'(nbits) - 1);
                        cyc.push_back(tck(it.port, it.lastb && fin,
                                          it.rd ? 1'b0 : it.data[7 - k], merged, fin));
                    end
                end
                if (it.lastb)
                    cyc.push_back(tck(it.port, 1'b1, 1'b0, 8'h00, 1'b0));
            end
            default: ;
        endcase
        if (cyc.size() > 0)
            cyc[cyc.size() - 1].last = 1'b1;
        foreach (cyc[i])
            pending_tck.push_back(cyc[i]);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_tck.size() == 0) begin
                $error("TCK cycle on port %0d with none expected", port_out);
                error_count++;
            end else begin
                oldest_tck = pending_tck.pop_front();
                check_field("port_index_out", int'(oldest_tck.port), int'(port_out));
                check_field("tms_level", int'(oldest_tck.tms), int'(tms_level));
                check_field("tdi_level", int'(oldest_tck.tdi), int'(tdi_level));
                check_field("result_byte", int'(oldest_tck.rbyte), int'(result_byte));
                check_field("byte_done", int'(oldest_tck.done), int'(byte_done));
                check_field("last", int'(oldest_tck.last), int'(last));
            end
        end
    end

    // Offers one transaction after a random number of idle cycles and
    // returns at the clock edge that accepts it.
    task automatic send_item(input jtag_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= it.command;
        port_index <= it.port;
        select_ir  <= it.ir;
        read_mode  <= it.rd;
        first_byte <= it.first;
        last_byte  <= it.lastb;
        bit_count  <= it.bc;
        data_byte  <= it.data;
        tdo_bits   <= it.tdo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tck_cycles(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tck.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic jtag_item_t make_item(input logic [1:0] cmd, input logic [1:0] port,
                                             input logic ir, input logic rd,
                                             input logic first, input logic lastb,
                                             input logic [3:0] bc, input logic [7:0] data,
                                             input logic [7:0] tdo);
        jtag_item_t it;
        it.command = cmd;
        it.port    = port;
        it.ir      = ir;
        it.rd      = rd;
        it.first   = first;
        it.lastb   = lastb;
        it.bc      = bc;
        it.data    = data;
        it.tdo     = tdo;
        return it;
    endfunction

    function automatic jtag_item_t random_item();
        return make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
    endfunction

    // A well-formed scan of one to four bytes; the last byte's count is
    // mostly in range, sometimes above eight.
    task automatic send_random_scan();
        logic [1:0] port;
        logic       ir;
        logic       rd;
        logic [3:0] bc;
        int         nbytes;
        int         b;
        port   = 2'($urandom_range(0, 3));
        ir     = 1'($urandom_range(0, 1));
        rd     = 1'($urandom_range(0, 1));
        nbytes = $urandom_range(1, 4);
        for (b = 0; b < nbytes; b++) begin
            if (b != nbytes - 1)
                bc = 4'($urandom_range(0, 15));
            else if ($urandom_range(0, 9) == 0)
                bc = 4'($urandom_range(9, 15));
            else
                bc = 4'($urandom_range(0, 8));
            send_item(make_item(CMD_SCAN, port, ir, rd, b == 0, b == nbytes - 1, bc,
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(make_item(CMD_RESET, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00, 8'h00));
        send_item(make_item(CMD_RESET, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 4'd15, 8'hFF, 8'hFF));
        send_item(make_item(CMD_RUN, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00, 8'h00));
        send_item(make_item(CMD_RUN, 2'd2, 1'b1, 1'b1, 1'b1, 1'b1, 4'd8, 8'hFF, 8'hFF));
        send_item(make_item(CMD_SCAN, 2'd0, 1'b1, 1'b0, 1'b1, 1'b1, 4'd8, 8'hA5, 8'h00));
        send_item(make_item(CMD_SCAN, 2'd3, 1'b0, 1'b1, 1'b1, 1'b1, 4'd8, 8'h00, 8'hFF));
        // Empty scans: no move to Shift, one TMS=1 clock carries the byte.
        send_item(make_item(CMD_SCAN, 2'd1, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0, 8'h3C, 8'hC3));
        send_item(make_item(CMD_SCAN, 2'd2, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0, 8'hFF, 8'h00));
        // Three-byte DR read with a short last byte.
        send_item(make_item(CMD_SCAN, 2'd0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, 8'hFF, 8'h5A));
        send_item(make_item(CMD_SCAN, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd15, 8'h12, 8'hC3));
        send_item(make_item(CMD_SCAN, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, 4'd5, 8'hFF, 8'h00));
        // IR write whose later last byte has a zero count.
        send_item(make_item(CMD_SCAN, 2'd3, 1'b1, 1'b0, 1'b1, 1'b0, 4'd8, 8'h81, 8'h00));
        send_item(make_item(CMD_SCAN, 2'd3, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 8'h7E, 8'hFF));
        // Counts above eight are clamped.
        send_item(make_item(CMD_SCAN, 2'd1, 1'b0, 1'b1, 1'b1, 1'b1, 4'd15, 8'h0F, 8'hF0));
        send_item(make_item(CMD_SCAN, 2'd2, 1'b1, 1'b0, 1'b1, 1'b1, 4'd9, 8'hFF, 8'hAA));
        // Scan bytes without an opening byte are shifted as given.
        send_item(make_item(CMD_SCAN, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd3, 8'hE0, 8'h00));
        send_item(make_item(CMD_SCAN, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, 4'd2, 8'h55, 8'h99));
        send_item(make_item(CMD_UNUSED, 2'd2, 1'b1, 1'b1, 1'b1, 1'b1, 4'd8, 8'hFF, 8'hFF));
        send_item(make_item(CMD_SCAN, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1, 8'h80, 8'h7F));
        send_item(make_item(CMD_RESET, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00, 8'h00));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_level,
                                       input int n_items);
        int         start;
        int         pick;
        jtag_item_t it;
        send_idle_pct = idle_pct;
        stall_pct     = stall_level;
        start         = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_random_scan();
            end else begin
                it = random_item();
                if (pick < 80)
                    it.command = CMD_RESET;
                else if (pick < 88)
                    it.command = CMD_RUN;
                send_item(it);
            end
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering transactions, so the block fills and stalls its input.
    task automatic test_backpressure();
        int start;
        send_idle_pct = 0;
        stall_pct     = 20;
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        start       = items_sent;
        while (items_sent - start < 20)
            send_random_scan();
        wait_drained();
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic(0, 0, 60);
        test_random_traffic(72, 0, 60);
        test_random_traffic(0, 72, 60);
        test_random_traffic(38, 38, 60);
        test_backpressure();
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/jss_pkg.sv
hw/rtl/jss_datapath.sv
hw/rtl/jss_controller.sv
hw/rtl/jtag_scan_sequencer_top.sv
test/tb_top.sv
